FILE: rtl/core/ptr_pkg.sv
package ptr_pkg;

    localparam int NUM_PAGES_DEF  = 16;
    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_WORDS_DEF = 16;

    localparam int ADDR_W  = 8;
    localparam int TIME_W  = 32;
    localparam int RAND_W  = 8;
    localparam int FRAME_W = 3;
    localparam int PADDR_W = 7;
    localparam int EPAGE_W = 4;
    localparam int POL_W   = 3;

    localparam logic [POL_W-1:0] POL_SECOND = 3'd0;
    localparam logic [POL_W-1:0] POL_LRU    = 3'd1;
    localparam logic [POL_W-1:0] POL_WSCLK  = 3'd2;
    localparam logic [POL_W-1:0] POL_FIFO   = 3'd3;
    localparam logic [POL_W-1:0] POL_NRU    = 3'd4;

    localparam logic [POL_W-1:0]  POLICY_RESET = POL_LRU;
    localparam logic [TIME_W-1:0] AGE_RESET    = 32'd100;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_AGE    = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch request, touch page
        logic scan_init; // reset scan index / counters
        logic scan_step; // evaluate one frame or one NRU remainder bit
        logic nru_pick;  // second NRU pass setup
        logic install;   // commit victim
        logic finish;    // load output register
    } ptr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic scan_done;
    } ptr_sts_t;

endpackage

FILE: rtl/core/ptr_datapath.sv
module ptr_datapath #(
    parameter int NUM_PAGES  = ptr_pkg::NUM_PAGES_DEF,
    parameter int NUM_FRAMES = ptr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_WORDS = ptr_pkg::PAGE_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptr_pkg::ptr_cmd_t             cmd,
    output ptr_pkg::ptr_sts_t             sts,
    input  logic [ptr_pkg::POL_W-1:0]     policy,
    input  logic [ptr_pkg::TIME_W-1:0]    age_threshold,
    input  logic [ptr_pkg::ADDR_W-1:0]    in_address,
    input  logic [ptr_pkg::TIME_W-1:0]    in_now,
    input  logic [ptr_pkg::RAND_W-1:0]    in_rand,
    output logic                          res_hit,
    output logic [ptr_pkg::FRAME_W-1:0]   res_frame,
    output logic [ptr_pkg::PADDR_W-1:0]   res_paddr,
    output logic                          res_evicted,
    output logic [ptr_pkg::EPAGE_W-1:0]   res_epage,
    output logic                          res_forced
);
    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int OW = $clog2(NUM_PAGES + NUM_FRAMES); // owner may exceed pages
    localparam int SW = $clog2(2 * NUM_FRAMES + 1);
    localparam int OFFW = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int RAND_W_L = ptr_pkg::RAND_W;
    localparam int MBW = $clog2(RAND_W_L);

    logic [NUM_PAGES-1:0]  present_reg, refd_reg;
    logic [FW-1:0]         pframe_reg [NUM_PAGES];
    logic [31:0]           stamp_reg  [NUM_PAGES];
    logic [31:0]           ptime_reg  [NUM_PAGES];
    logic [OW-1:0]         owner_reg  [NUM_FRAMES];
    logic [31:0]           stamp_cnt_reg;
    logic [FW-1:0]         qhand_reg, whand_reg;

    logic [PW-1:0]   page_reg;
    logic [OFFW-1:0] off_reg;
    logic [31:0]     now_reg;
    logic [RAND_W_L-1:0] rand_reg;

    logic [SW-1:0]   idx_reg;   // scan step count
    logic [FW-1:0]   cur_reg;   // frame under look
    logic            done_reg;
    logic [FW-1:0]   victim_reg;
    logic            forced_reg;
    logic [31:0]     best_reg;
    logic [CW-1:0]   cnt_reg;   // NRU class count / seen
    logic            nru_p2_reg;
    logic            anyclr_reg;
    logic [CW-1:0]   div_reg;   // NRU class size
    logic [CW-1:0]   rem_reg;   // random_pick mod class size
    logic [MBW-1:0]  mbit_reg;  // random_pick bit being shifted in
    logic            mod_busy_reg;

    // decoded address
    logic [ptr_pkg::ADDR_W-1:0] pg_full;
    assign pg_full = ptr_pkg::ADDR_W'(in_address / PAGE_WORDS);

    // current frame view
    logic [OW-1:0] own;
    logic          ovalid, fref;
    logic [PW-1:0] opage;
    logic [31:0]   fstamp, ftime, age;
    assign own    = owner_reg[cur_reg];
    assign ovalid = own < OW'(NUM_PAGES);
    assign opage  = own[PW-1:0];
    assign fref   = ovalid && refd_reg[opage];
    assign fstamp = ovalid ? stamp_reg[opage] : '0;
    assign ftime  = ovalid ? ptime_reg[opage] : '0;
    assign age    = now_reg - ftime;

    // restoring remainder step
    logic [CW:0] rem_sh;
    assign rem_sh = {rem_reg, rand_reg[mbit_reg]};

    function automatic logic [FW-1:0] nxt(input logic [FW-1:0] f);
        return (f == FW'(NUM_FRAMES - 1)) ? '0 : f + 1'b1;
    endfunction

    assign sts.hit       = present_reg[page_reg];
    assign sts.scan_done = done_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int p = 0; p < NUM_PAGES; p++) begin
                present_reg[p] <= (p < NUM_FRAMES);
                refd_reg[p]    <= 1'b0;
                pframe_reg[p]  <= (p < NUM_FRAMES) ? FW'(p) : '0;
                stamp_reg[p]   <= '0;
                ptime_reg[p]   <= '0;
            end
            for (int f = 0; f < NUM_FRAMES; f++)
                owner_reg[f] <= OW'(f);
            stamp_cnt_reg <= '0;
            qhand_reg     <= '0;
            whand_reg     <= '0;
            page_reg      <= '0;
            off_reg       <= '0;
            now_reg       <= '0;
            rand_reg      <= '0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            cur_reg       <= '0;
            victim_reg    <= '0;
            best_reg      <= '0;
            cnt_reg       <= '0;
            nru_p2_reg    <= 1'b0;
            anyclr_reg    <= 1'b0;
            forced_reg    <= 1'b0;
            div_reg       <= '0;
            rem_reg       <= '0;
            mbit_reg      <= '0;
            mod_busy_reg  <= 1'b0;
        end else begin
            if (cmd.start) begin
                page_reg <= PW'(pg_full % NUM_PAGES);
                off_reg  <= OFFW'(in_address % PAGE_WORDS);
                now_reg  <= in_now;
                rand_reg <= in_rand;
                refd_reg[PW'(pg_full % NUM_PAGES)]  <= 1'b1;
                stamp_reg[PW'(pg_full % NUM_PAGES)] <= stamp_cnt_reg;
                ptime_reg[PW'(pg_full % NUM_PAGES)] <= in_now;
                stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
            end
            if (cmd.scan_init) begin
                idx_reg    <= '0;
                done_reg   <= 1'b0;
                forced_reg <= 1'b0;
                cnt_reg    <= '0;
                nru_p2_reg <= 1'b0;
                victim_reg <= '0;
                unique case (policy)
                    ptr_pkg::POL_SECOND, ptr_pkg::POL_FIFO: cur_reg <= qhand_reg;
                    ptr_pkg::POL_WSCLK: cur_reg <= whand_reg;
                    default: cur_reg <= '0;
                endcase
            end
            if (cmd.nru_pick) begin
                anyclr_reg   <= cnt_reg != '0;
                div_reg      <= (cnt_reg != '0) ? cnt_reg : CW'(NUM_FRAMES);
                rem_reg      <= '0;
                mbit_reg     <= MBW'(RAND_W_L - 1);
                mod_busy_reg <= 1'b1;
                cnt_reg      <= '0;
                cur_reg      <= '0;
                nru_p2_reg   <= 1'b1;
                done_reg     <= 1'b0;
            end
            if (cmd.scan_step && !done_reg) begin
                idx_reg <= idx_reg + 1'b1;
                unique case (policy)
                    ptr_pkg::POL_SECOND: begin
                        qhand_reg <= nxt(cur_reg);
                        if (fref && idx_reg < SW'(NUM_FRAMES)) begin
                            refd_reg[opage] <= 1'b0;
                            cur_reg <= nxt(cur_reg);
                        end else begin
                            victim_reg <= cur_reg;
                            done_reg   <= 1'b1;
                        end
                    end
                    ptr_pkg::POL_FIFO: begin
                        victim_reg <= cur_reg;
                        qhand_reg  <= nxt(cur_reg);
                        done_reg   <= 1'b1;
                    end
                    ptr_pkg::POL_WSCLK: begin
                        if (fref) begin
                            refd_reg[opage]  <= 1'b0;
                            ptime_reg[opage] <= now_reg;
                        end
                        if (!fref && age > age_threshold) begin
                            victim_reg <= cur_reg;
                            done_reg   <= 1'b1;
                        end else begin
                            whand_reg <= nxt(cur_reg);
                            cur_reg   <= nxt(cur_reg);
                            if (idx_reg == SW'(2 * NUM_FRAMES - 1)) begin
                                victim_reg <= nxt(cur_reg);
                                forced_reg <= 1'b1;
                                done_reg   <= 1'b1;
                            end
                        end
                    end
                    ptr_pkg::POL_NRU: begin
                        if (!nru_p2_reg) begin
                            cur_reg <= nxt(cur_reg);
                            if (!fref) cnt_reg <= cnt_reg + 1'b1;
                            if (cur_reg == FW'(NUM_FRAMES - 1)) done_reg <= 1'b1;
                        end else if (mod_busy_reg) begin
                            // one bit of random_pick per step, MSB first
                            if (rem_sh >= {1'b0, div_reg})
                                rem_reg <= CW'(rem_sh - {1'b0, div_reg});
                            else
                                rem_reg <= rem_sh[CW-1:0];
                            mbit_reg <= mbit_reg - 1'b1;
                            if (mbit_reg == '0) mod_busy_reg <= 1'b0;
                        end else begin
                            cur_reg <= nxt(cur_reg);
                            if (!(anyclr_reg && fref)) begin
                                if (cnt_reg == rem_reg) begin
                                    victim_reg <= cur_reg;
                                    done_reg   <= 1'b1;
                                end
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (cur_reg == '0 || fstamp < best_reg) begin
                            best_reg   <= fstamp;
                            victim_reg <= cur_reg;
                        end
                        cur_reg <= nxt(cur_reg);
                        if (cur_reg == FW'(NUM_FRAMES - 1)) done_reg <= 1'b1;
                    end
                endcase
            end
            if (cmd.install) begin
                if (owner_reg[victim_reg] < OW'(NUM_PAGES)) begin
                    present_reg[owner_reg[victim_reg][PW-1:0]] <= 1'b0;
                    refd_reg[owner_reg[victim_reg][PW-1:0]]    <= 1'b0;
                end
                owner_reg[victim_reg] <= OW'(page_reg);
                present_reg[page_reg] <= 1'b1;
                refd_reg[page_reg]    <= 1'b1;
                pframe_reg[page_reg]  <= victim_reg;
            end
        end
    end

    // result register, loaded before install so the old owner is still visible
    logic [FW-1:0] ofr;
    logic          oev;
    assign ofr = present_reg[page_reg] ? pframe_reg[page_reg] : victim_reg;
    assign oev = owner_reg[victim_reg] < OW'(NUM_PAGES);

    always_ff @(posedge clk) begin
        if (cmd.finish) begin
            res_hit   <= sts.hit;
            res_frame <= ptr_pkg::FRAME_W'(ofr);
            res_paddr <= ptr_pkg::PADDR_W'(ofr * PAGE_WORDS + off_reg);
            res_evicted <= !sts.hit && oev;
            res_epage <= (!sts.hit && oev)
                         ? ptr_pkg::EPAGE_W'(owner_reg[victim_reg]) : '0;
            res_forced <= !sts.hit && forced_reg;
        end
    end
endmodule

FILE: rtl/core/ptr_ctrl.sv
module ptr_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic                      out_fire,
    input  logic [ptr_pkg::POL_W-1:0] policy,
    input  ptr_pkg::ptr_sts_t         sts,
    output ptr_pkg::ptr_cmd_t         cmd,
    output logic                      in_ready,
    output logic                      out_valid
);
    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_NRU2, S_INST, S_FIN, S_OUT} state_t;
    state_t state_reg, state_next;
    logic   ov_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin cmd.start = 1'b1; state_next = S_CHECK; end
            S_CHECK: begin
                if (sts.hit) state_next = S_FIN;
                else begin cmd.scan_init = 1'b1; state_next = S_SCAN; end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    cmd.scan_step = 1'b0;
                    if (policy == ptr_pkg::POL_NRU) begin
                        cmd.nru_pick = 1'b1;
                        state_next = S_NRU2;
                    end else state_next = S_FIN;
                end
            end
            S_NRU2: begin
                cmd.scan_step = !sts.scan_done;
                if (sts.scan_done) state_next = S_FIN;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = sts.hit ? S_OUT : S_INST;
            end
            S_INST: begin cmd.install = 1'b1; state_next = S_OUT; end
            S_OUT: if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // result is loaded from the pre-install view (old owner of the victim),
    // install follows on a miss
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= (state_next == S_OUT);
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
endmodule

FILE: rtl/core/page_table_with_replacement.sv
// Page table with selectable replacement (second chance, LRU, WSClock, FIFO,
// NRU). One request at a time: a hit needs no victim scan; a miss adds its
// victim-scan steps: one step for FIFO, NUM_FRAMES for LRU, up to
// NUM_FRAMES+1 for second chance, up to 2*NUM_FRAMES for WSClock, and for NRU
// a NUM_FRAMES class-count pass, a pick setup, RAND_W remainder steps
// (random_pick mod class size) and up to NUM_FRAMES selection steps. The next
// request is accepted in the cycle after the result is taken. The single
// frame-scan datapath runs these steps in turn. Configuration writes are
// taken at any time but must only be issued while idle.
module page_table_with_replacement #(
    parameter int NUM_PAGES  = ptr_pkg::NUM_PAGES_DEF,
    parameter int NUM_FRAMES = ptr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_WORDS = ptr_pkg::PAGE_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // address[7:0], now[39:8], random_pick[47:40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // hit[0], frame[3:1], physical_address[10:4],
                                       // evicted[11], evicted_page[15:12], forced_pick[16]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    logic [ptr_pkg::POL_W-1:0]  policy_reg;
    logic [ptr_pkg::TIME_W-1:0] age_reg;
    ptr_pkg::ptr_cmd_t cmd;
    ptr_pkg::ptr_sts_t sts;
    logic in_fire, out_fire;
    logic r_hit, r_ev, r_forced;
    logic [2:0] r_frame;
    logic [6:0] r_pa;
    logic [3:0] r_ep;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            policy_reg <= ptr_pkg::POLICY_RESET;
            age_reg    <= ptr_pkg::AGE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ptr_pkg::CFG_POLICY: policy_reg <= cfg_data[2:0];
                ptr_pkg::CFG_AGE:    age_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    ptr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .policy(policy_reg), .sts(sts), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    ptr_datapath #(.NUM_PAGES(NUM_PAGES), .NUM_FRAMES(NUM_FRAMES),
                   .PAGE_WORDS(PAGE_WORDS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .policy(policy_reg), .age_threshold(age_reg),
        .in_address(s_axis_tdata[7:0]), .in_now(s_axis_tdata[39:8]),
        .in_rand(s_axis_tdata[47:40]),
        .res_hit(r_hit), .res_frame(r_frame), .res_paddr(r_pa),
        .res_evicted(r_ev), .res_epage(r_ep), .res_forced(r_forced)
    );

    assign m_axis_tdata = {7'b0, r_forced, r_ep, r_ev, r_pa, r_frame, r_hit};
endmodule
